FILE: rtl/cphdt_pkg.sv
package cphdt_pkg;

   localparam int unsigned ENTRIES = 256;
   localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
   localparam int unsigned TAG_W   = 64;
   localparam int unsigned ROW_W   = 4 * TAG_W;

   localparam logic [63:0] MIX_MUL_A  = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_MUL_B  = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] WORD_KEY   = 64'ha0761d6478bd642f;
   localparam logic [63:0] SEED_RESET = 64'h9e3779b97f4a7c15;
   localparam int unsigned MIX_SHIFT  = 33;

   // tag word slots, in the order they are computed
   localparam logic [1:0] WORD_SITE_LO   = 2'd0;
   localparam logic [1:0] WORD_SITE_HI   = 2'd1;
   localparam logic [1:0] WORD_TARGET_LO = 2'd2;
   localparam logic [1:0] WORD_TARGET_HI = 2'd3;

   typedef enum logic [2:0] {
      HOP_NONE,
      HOP_LOAD,
      HOP_XS,
      HOP_MUL0,
      HOP_MUL1,
      HOP_MUL2,
      HOP_SAVE
   } hop_type;

   typedef struct packed {
      logic       load;
      hop_type    hop;
      logic [1:0] word;
      logic       kb;
      logic       search;
      logic       finish;
      logic       found;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic done;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/cphdt_ram.sv
module cphdt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cphdt_ctrl.sv
module cphdt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cphdt_pkg::sts_type sts,
   output cphdt_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   localparam logic [3:0] STEP_LAST = 4'd10;

   state_type  state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] word_ff, word_in;
   logic       found_ff, found_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      word_in  = word_ff;
      found_in = found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HASH;
               step_in  = '0;
               word_in  = cphdt_pkg::WORD_SITE_LO;
            end
         end
         ST_HASH: begin
            if (step_ff == STEP_LAST) begin
               step_in = '0;
               if (word_ff == cphdt_pkg::WORD_TARGET_HI) begin
                  state_in = ST_SEARCH;
               end else begin
                  word_in = word_ff + 2'd1;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_SEARCH: begin
            if (sts.hit) begin
               found_in = 1'b1;
               state_in = ST_FINISH;
            end else if (sts.done) begin
               found_in = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         word_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         word_ff  <= word_in;
         found_ff <= found_in;
      end
   end

   // one fmix64 per tag word: xor-shift, multiply in three partial products, twice, then a final xor-shift
   always_comb begin
      cmd        = '0;
      cmd.hop    = cphdt_pkg::HOP_NONE;
      cmd.word   = word_ff;
      cmd.found  = found_ff;
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.search = (state_ff == ST_SEARCH);
      cmd.finish = (state_ff == ST_FINISH) && sts.out_free;
      if (state_ff == ST_HASH) begin
         unique case (step_ff)
            4'd0:                      cmd.hop = cphdt_pkg::HOP_LOAD;
            4'd1, 4'd5, 4'd9:          cmd.hop = cphdt_pkg::HOP_XS;
            4'd2, 4'd6:                cmd.hop = cphdt_pkg::HOP_MUL0;
            4'd3, 4'd7:                cmd.hop = cphdt_pkg::HOP_MUL1;
            4'd4, 4'd8:                cmd.hop = cphdt_pkg::HOP_MUL2;
            4'd10:                     cmd.hop = cphdt_pkg::HOP_SAVE;
            default:                   cmd.hop = cphdt_pkg::HOP_NONE;
         endcase
         cmd.kb = (step_ff > 4'd5);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_HASH) && (step_ff == 4'd0))
      else $error("accepted item did not start hashing");

   a_finish_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && sts.out_free) |=> (state_ff == ST_IDLE))
      else $error("finish did not return to idle");

endmodule

FILE: rtl/cphdt_dp.sv
module cphdt_dp (
   input  logic               clock,
   input  logic               reset,
   input  cphdt_pkg::cmd_type cmd,
   output cphdt_pkg::sts_type sts,
   input  logic [63:0]        req_site_offset,
   input  logic [63:0]        req_target_offset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [63:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_pair_added,
   output logic               rsp_table_full,
   output logic [63:0]        rsp_site_tag_low,
   output logic [63:0]        rsp_site_tag_high,
   output logic [63:0]        rsp_target_tag_low,
   output logic [63:0]        rsp_target_tag_high
);

   localparam int unsigned IDX_W = cphdt_pkg::IDX_W;
   localparam int unsigned CNT_W = cphdt_pkg::CNT_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(cphdt_pkg::ENTRIES);

   logic [63:0] seed_ff, site_ff, target_ff;
   logic [63:0] v_ff, v_in, acc_ff, acc_in;
   logic [63:0] tag_ff [4];
   logic [63:0] kconst, prod;
   logic [31:0] mul_a, mul_b;

   logic [CNT_W-1:0] count_ff, count_in, ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   logic             more, rd_en, wr_en, room;
   logic [cphdt_pkg::ROW_W-1:0] key, rd_data;

   logic        out_valid_ff, out_valid_in;
   logic        learned_ff, full_ff;
   logic [63:0] out_sl_ff, out_sh_ff, out_tl_ff, out_th_ff;

   assign csr_ready = 1'b1;

   // 64x64 low product from three 32x32 partial products
   always_comb begin
      kconst = cmd.kb ? cphdt_pkg::MIX_MUL_B : cphdt_pkg::MIX_MUL_A;
      case (cmd.hop)
         cphdt_pkg::HOP_MUL1: begin
            mul_a = v_ff[31:0];
            mul_b = kconst[63:32];
         end
         cphdt_pkg::HOP_MUL2: begin
            mul_a = v_ff[63:32];
            mul_b = kconst[31:0];
         end
         default: begin
            mul_a = v_ff[31:0];
            mul_b = kconst[31:0];
         end
      endcase
      prod = 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      v_in   = v_ff;
      acc_in = acc_ff;
      case (cmd.hop)
         cphdt_pkg::HOP_LOAD: begin
            case (cmd.word)
               cphdt_pkg::WORD_SITE_LO:   v_in = site_ff ^ seed_ff;
               cphdt_pkg::WORD_SITE_HI:   v_in = tag_ff[0] ^ cphdt_pkg::WORD_KEY;
               cphdt_pkg::WORD_TARGET_LO: v_in = target_ff ^ seed_ff;
               default:                   v_in = tag_ff[2] ^ cphdt_pkg::WORD_KEY;
            endcase
         end
         cphdt_pkg::HOP_XS:   v_in   = v_ff ^ (v_ff >> cphdt_pkg::MIX_SHIFT);
         cphdt_pkg::HOP_MUL0: acc_in = prod;
         cphdt_pkg::HOP_MUL1: acc_in = acc_ff + {prod[31:0], 32'h0};
         cphdt_pkg::HOP_MUL2: v_in   = acc_ff + {prod[31:0], 32'h0};
         default: ;
      endcase
   end

   // linear search over stored rows, one read issued per cycle
   assign more    = (ptr_ff < count_ff);
   assign rd_en   = cmd.search && more;
   assign pend_in = rd_en;
   assign ptr_in  = cmd.load ? '0 : (rd_en ? ptr_ff + 1'b1 : ptr_ff);
   assign key     = {tag_ff[0], tag_ff[1], tag_ff[2], tag_ff[3]};

   assign sts.hit      = pend_ff && (rd_data == key);
   assign sts.done     = !more && !pend_ff;
   assign sts.out_free = !out_valid_ff || rsp_ready;

   assign room     = (count_ff < FULL_COUNT);
   assign wr_en    = cmd.finish && !cmd.found && room;
   assign count_in = wr_en ? count_ff + 1'b1 : count_ff;

   assign out_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   cphdt_ram #(
      .WIDTH (cphdt_pkg::ROW_W),
      .DEPTH (cphdt_pkg::ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (key),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= cphdt_pkg::SEED_RESET;
         count_ff     <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            seed_ff <= csr_data;
         end
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         site_ff   <= req_site_offset;
         target_ff <= req_target_offset;
      end
      v_ff   <= v_in;
      acc_ff <= acc_in;
      if (cmd.hop == cphdt_pkg::HOP_SAVE) begin
         tag_ff[cmd.word] <= v_ff;
      end
      if (cmd.finish) begin
         learned_ff <= wr_en;
         full_ff    <= !cmd.found && !room;
         out_sl_ff  <= tag_ff[0];
         out_sh_ff  <= tag_ff[1];
         out_tl_ff  <= tag_ff[2];
         out_th_ff  <= tag_ff[3];
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_pair_added      = learned_ff;
   assign rsp_table_full      = full_ff;
   assign rsp_site_tag_low    = out_sl_ff;
   assign rsp_site_tag_high   = out_sh_ff;
   assign rsp_target_tag_low  = out_tl_ff;
   assign rsp_target_tag_high = out_th_ff;

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("append did not advance the entry count");

   a_append_has_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < FULL_COUNT) && !cmd.found)
      else $error("append into a full table or of a present pair");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!out_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

FILE: rtl/call_pair_hash_dedup_table_core.sv
// Call pair dedup table: hashes a (site, target) offset pair into two 128-bit
// fmix64 tags and appends new tag pairs to a table of distinct pairs if room.
// Channels: req_* carries one call pair per item, rsp_* returns one result
// item per request (flags plus the four tag words), csr_* writes the hash seed.
// The seed port is always ready; write it only while no item is in flight.
// Per item: accept, then hashing (four fmix64 runs on one 32x32 multiplier,
// three partial products per 64-bit multiply), then a linear search of the
// table memory at one row per cycle, then the result write. The table holds
// up to 256 entries. One item is worked at a time.
// Results sit in an output register; the next item is accepted while a result
// waits, and only the final write stalls if rsp_ready stays low.
// Reset: seed returns to its default, the table is empty, no result pending.
// Table contents need no clearing; only rows below the entry count are read.
module call_pair_hash_dedup_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_site_offset,
   input  logic [63:0] req_target_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pair_added,
   output logic        rsp_table_full,
   output logic [63:0] rsp_site_tag_low,
   output logic [63:0] rsp_site_tag_high,
   output logic [63:0] rsp_target_tag_low,
   output logic [63:0] rsp_target_tag_high,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data
);

   cphdt_pkg::cmd_type cmd;
   cphdt_pkg::sts_type sts;

   cphdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cphdt_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_site_offset     (req_site_offset),
      .req_target_offset   (req_target_offset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pair_added      (rsp_pair_added),
      .rsp_table_full      (rsp_table_full),
      .rsp_site_tag_low    (rsp_site_tag_low),
      .rsp_site_tag_high   (rsp_site_tag_high),
      .rsp_target_tag_low  (rsp_target_tag_low),
      .rsp_target_tag_high (rsp_target_tag_high)
   );

endmodule
